[hw/rtl/dmvt_pkg.sv]
package dmvt_pkg;

  localparam int unsigned VecLen = 4;
  localparam int unsigned MatCount = 2;
  localparam int unsigned StoreDepth = MatCount * VecLen * VecLen;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef struct packed {
    logic               operation;
    logic               matrix_select;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic               chain_mode;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
    logic               last_vertex;
  } in_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] first_w;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] second_w;
    logic               batch_end;
  } out_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

[hw/rtl/dual_matrix_vertex_transform_unit.sv]
// Dual-matrix vertex transform in s15.16 fixed point.
// The input channel carries load beats and transform beats. A load beat writes
// one coefficient of either 4x4 matrix and is taken with no result.
// A transform beat carries a vertex; four row lanes multiply it by the first
// matrix, then by the second matrix, applied either to the same vertex or to
// the saturated first result. The output channel carries one beat per
// transform with both result vectors and the batch end mark.
// A transform beat steps through the states MUL_A, SUM_A, MUL_B, SUM_B and OUT;
// its result beat is registered on leaving OUT, and no input beat is taken until
// IDLE is reached again. The four lanes are shared by the two matrices, each
// pass going through the product registers and then the saturated sum register.
// A coefficient load may directly precede a transform.
// Reset clears both matrices to zero and empties the output register.
// While the receiver stalls, the finished result waits in the output register;
// the next transform runs and then holds its result in the lanes, with the
// input stalled, until the output register is free. Load beats are still taken
// while the output beat waits, as long as the unit is idle.
module dual_matrix_vertex_transform_unit import dmvt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int COEF_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_A,
    S_SUM_A,
    S_MUL_B,
    S_SUM_B,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  logic               in_acc;
  logic               wr_en;
  logic               xf_start;
  logic               out_free;
  logic               out_load;
  lane_ctrl_t         lane_ctrl;
  logic signed [CW-1:0] coef [VecLen][VecLen];
  logic signed [31:0] vec [VecLen];
  logic signed [31:0] lane_res [VecLen];
  logic signed [31:0] v_q [VecLen];
  logic signed [31:0] first_q [VecLen];
  logic               chain_q;
  logic               last_q;
  out_t               out_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && (in_data_i.operation == OP_LOAD);
  assign xf_start   = in_acc && (in_data_i.operation == OP_XFORM);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_OUT) && out_free;

  assign lane_ctrl.mul_en = (state_q == S_MUL_A) || (state_q == S_MUL_B);
  assign lane_ctrl.sum_en = (state_q == S_SUM_A) || (state_q == S_SUM_B);

  always_comb begin
    for (int c = 0; c < VecLen; c++) begin
      vec[c] = ((state_q == S_MUL_B) && chain_q) ? lane_res[c] : v_q[c];
    end
  end

  dmvt_coef_bank #(
    .CW(CW)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_mat_i (in_data_i.matrix_select),
    .wr_idx_i (in_data_i.coef_index),
    .wr_data_i(in_data_i.coef_value),
    .rd_mat_i (state_q == S_MUL_B),
    .coef_o   (coef)
  );

  for (genvar r = 0; r < VecLen; r++) begin : g_lane
    dmvt_lane #(
      .CW       (CW),
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .ctrl_i(lane_ctrl),
      .coef_i(coef[r]),
      .vec_i (vec),
      .res_o (lane_res[r])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (xf_start) state_d = S_MUL_A;
      S_MUL_A: state_d = S_SUM_A;
      S_SUM_A: state_d = S_MUL_B;
      S_MUL_B: state_d = S_SUM_B;
      S_SUM_B: state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xf_start) begin
      v_q[0]  <= in_data_i.vx;
      v_q[1]  <= in_data_i.vy;
      v_q[2]  <= in_data_i.vz;
      v_q[3]  <= in_data_i.vw;
      chain_q <= in_data_i.chain_mode;
      last_q  <= in_data_i.last_vertex;
    end
    if (state_q == S_MUL_B) begin
      first_q <= lane_res;
    end
    if (out_load) begin
      out_q.first_x   <= first_q[0];
      out_q.first_y   <= first_q[1];
      out_q.first_z   <= first_q[2];
      out_q.first_w   <= first_q[3];
      out_q.second_x  <= lane_res[0];
      out_q.second_y  <= lane_res[1];
      out_q.second_z  <= lane_res[2];
      out_q.second_w  <= lane_res[3];
      out_q.batch_end <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/dmvt_coef_bank.sv]
module dmvt_coef_bank import dmvt_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic                 wr_mat_i,
  input  logic [3:0]           wr_idx_i,
  input  logic signed [31:0]   wr_data_i,
  input  logic                 rd_mat_i,
  output logic signed [CW-1:0] coef_o [VecLen][VecLen]
);

  logic signed [CW-1:0] store_q [StoreDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      store_q[{wr_mat_i, wr_idx_i}] <= wr_data_i[CW-1:0];
    end
  end

  // Lane r sees row r of the selected matrix; entries are column-major.
  always_comb begin
    for (int r = 0; r < VecLen; r++) begin
      for (int c = 0; c < VecLen; c++) begin
        coef_o[r][c] = rd_mat_i ? store_q[16 + c * 4 + r] : store_q[c * 4 + r];
      end
    end
  end

endmodule

[hw/rtl/dmvt_lane.sv]
module dmvt_lane import dmvt_pkg::*; #(
  parameter int CW = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  lane_ctrl_t           ctrl_i,
  input  logic signed [CW-1:0] coef_i [VecLen],
  input  logic signed [31:0]   vec_i [VecLen],
  output logic signed [31:0]   res_o
);

  localparam int PW = CW + 32;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MaxVal = {{(SW - 32){1'b0}}, 1'b0, {31{1'b1}}};
  localparam logic signed [SW-1:0] MinVal = {{(SW - 31){1'b1}}, {31{1'b0}}};

  logic signed [PW-1:0] prod_q [VecLen];
  logic signed [SW-1:0] sum;
  logic signed [31:0]   res_d;
  logic signed [31:0]   res_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      for (int c = 0; c < VecLen; c++) begin
        prod_q[c] <= PW'(coef_i[c]) * PW'(vec_i[c]);
      end
    end
  end

  // Each product is floored by the arithmetic shift before the exact sum.
  always_comb begin
    sum = '0;
    for (int c = 0; c < VecLen; c++) begin
      sum = sum + SW'(prod_q[c] >>> FRAC_BITS);
    end
    if (sum > MaxVal) begin
      res_d = 32'sh7fffffff;
    end else if (sum < MinVal) begin
      res_d = 32'sh80000000;
    end else begin
      res_d = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
